/* hw/rtl/ttt_pkg.sv */
`default_nettype none

package ttt_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int TAG_W    = 16;
    localparam int DELAY_W  = 32;
    localparam int PER_W    = 32;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;

    localparam int SLOTS_DEFAULT = 16;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POLL   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 2'd3;

    // operations carried by the action wave
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd3;
    localparam logic [OP_W-1:0] OP_FIRE   = 3'd4;

    localparam logic [TIME_W-1:0] ONE_TICK  = 48'd1;
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_ZERO = '0;

    // action wave: rippled through the cell row, one cell a cycle
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic              found;
        logic              best_ok;
        logic [TIME_W-1:0] best_dl;
        logic [TAG_W-1:0]  fired_tag;
    } act_t;

    // summary wave: launched the cycle after the last action wave and follows it down the row
    typedef struct packed {
        logic              valid;
        logic              pending;
        logic              due;
        logic [TIME_W-1:0] best;
    } sum_t;

    // values broadcast to every cell while an item is in work
    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
        logic [PER_W-1:0]   period;
    } bcast_t;

endpackage

`default_nettype wire

/* hw/rtl/ttt_cell.sv */
`default_nettype none

// one timer slot; acts on the waves passing through and forwards them
module ttt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ttt_pkg::bcast_t bc,
    input  wire ttt_pkg::act_t   act_in,
    input  wire ttt_pkg::sum_t   sum_in,
    output ttt_pkg::act_t        act_out,
    output ttt_pkg::sum_t        sum_out
);

    logic                          used_reg, used_next;
    logic                          active_reg, active_next;
    logic                          periodic_reg, periodic_next;
    logic [ttt_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic [ttt_pkg::TIME_W-1:0]    dl_reg, dl_next;
    logic [ttt_pkg::PER_W-1:0]     per_reg, per_next;
    ttt_pkg::act_t                 act_reg, act_next;
    ttt_pkg::sum_t                 sum_reg, sum_next;

    logic [ttt_pkg::TIME_W-1:0]    arm_dl;
    logic [ttt_pkg::TIME_W-1:0]    reload_dl;
    logic [ttt_pkg::TIME_W-1:0]    diff;
    logic                          expired;
    logic                          due;
    logic                          tag_hit;

    assign arm_dl    = bc.now + {{(ttt_pkg::TIME_W-ttt_pkg::DELAY_W){1'b0}}, bc.delay};
    assign reload_dl = bc.now + {{(ttt_pkg::TIME_W-ttt_pkg::PER_W){1'b0}}, per_reg};
    assign diff      = dl_reg - bc.now;
    assign expired   = dl_reg <= bc.now;
    assign due       = active_reg && expired;
    assign tag_hit   = used_reg && (tag_reg == bc.tag);

    always_comb
    begin
        act_next      = act_in;
        sum_next      = sum_in;
        used_next     = used_reg;
        active_next   = active_reg;
        periodic_next = periodic_reg;
        tag_next      = tag_reg;
        dl_next       = dl_reg;
        per_next      = per_reg;

        if (act_in.valid)
        begin
            case (act_in.op)
                ttt_pkg::OP_START:
                begin
                    // first matching slot, or the first free one
                    if (!act_in.found && (tag_hit || !used_reg))
                    begin
                        act_next.found = 1'b1;
                        used_next      = 1'b1;
                        tag_next       = bc.tag;
                        dl_next        = arm_dl;
                        per_next       = bc.period;
                        active_next    = 1'b1;
                        periodic_next  = (bc.period != '0);
                    end
                end
                ttt_pkg::OP_CANCEL:
                begin
                    if (!act_in.found && tag_hit)
                    begin
                        act_next.found = 1'b1;
                        active_next    = 1'b0;
                    end
                end
                ttt_pkg::OP_SELECT:
                begin
                    if (due && (!act_in.best_ok || (dl_reg < act_in.best_dl)))
                    begin
                        act_next.best_ok = 1'b1;
                        act_next.best_dl = dl_reg;
                    end
                end
                ttt_pkg::OP_FIRE:
                begin
                    // lowest index holding the earliest due deadline
                    if (!act_in.found && act_in.best_ok && due && (dl_reg == act_in.best_dl))
                    begin
                        act_next.found     = 1'b1;
                        act_next.fired_tag = tag_reg;
                        if (periodic_reg && (per_reg != '0))
                        begin
                            dl_next = reload_dl;
                        end
                        else
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (sum_in.valid && active_reg)
        begin
            sum_next.pending = 1'b1;
            if (expired)
            begin
                sum_next.due = 1'b1;
            end
            else if (diff < sum_in.best)
            begin
                sum_next.best = diff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= 1'b0;
            active_reg   <= 1'b0;
            periodic_reg <= 1'b0;
            act_reg      <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            used_reg     <= used_next;
            active_reg   <= active_next;
            periodic_reg <= periodic_next;
            act_reg      <= act_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        dl_reg  <= dl_next;
        per_reg <= per_next;
    end

    assign act_out = act_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire

/* hw/rtl/ttt_ctrl.sv */
`default_nettype none

// sequencer: takes a command, launches the waves, builds the response
module ttt_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic [ttt_pkg::KIND_W-1:0]        kind,
    input  wire logic [ttt_pkg::TAG_W-1:0]         tag,
    input  wire logic [ttt_pkg::DELAY_W-1:0]       delay,
    input  wire logic [ttt_pkg::PER_W-1:0]         period,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic [ttt_pkg::STATUS_W-1:0]           status,
    output logic [ttt_pkg::TAG_W-1:0]              fired_tag,
    output logic                                   has_pending,
    output logic [ttt_pkg::TIME_W-1:0]             wait_ticks,
    output ttt_pkg::bcast_t                        bc,
    output ttt_pkg::act_t                          act_launch,
    output ttt_pkg::sum_t                          sum_launch,
    input  wire ttt_pkg::act_t                     act_end,
    input  wire ttt_pkg::sum_t                     sum_end
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_SELECT = 3'd2;
    localparam logic [2:0] S_SUMGO  = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [ttt_pkg::TIME_W-1:0]      time_reg, time_next;
    logic [ttt_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [ttt_pkg::TAG_W-1:0]       tag_reg, tag_next;
    logic [ttt_pkg::DELAY_W-1:0]     delay_reg, delay_next;
    logic [ttt_pkg::PER_W-1:0]       period_reg, period_next;
    logic                            found_reg, found_next;
    logic [ttt_pkg::TAG_W-1:0]       fired_reg, fired_next;
    logic                            pend_reg, pend_next;
    logic                            due_reg, due_next;
    logic [ttt_pkg::TIME_W-1:0]      best_reg, best_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [ttt_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [ttt_pkg::TAG_W-1:0]       rsp_tag_reg, rsp_tag_next;
    logic                            rsp_pend_reg, rsp_pend_next;
    logic [ttt_pkg::TIME_W-1:0]      rsp_wait_reg, rsp_wait_next;

    logic                            cmd_xfer;
    logic                            out_free;
    logic [ttt_pkg::STATUS_W-1:0]    done_status;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd_valid && cmd_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign bc.now    = time_reg;
    assign bc.tag    = tag_reg;
    assign bc.delay  = delay_reg;
    assign bc.period = period_reg;

    always_comb
    begin
        case (kind_reg)
            ttt_pkg::KIND_START:  done_status = found_reg ? ttt_pkg::ST_OK : ttt_pkg::ST_FULL;
            ttt_pkg::KIND_CANCEL: done_status = found_reg ? ttt_pkg::ST_OK
                                                          : ttt_pkg::ST_NOT_FOUND;
            ttt_pkg::KIND_POLL:   done_status = found_reg ? ttt_pkg::ST_OK
                                                          : ttt_pkg::ST_NONE_DUE;
            default:              done_status = ttt_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        kind_next      = kind_reg;
        tag_next       = tag_reg;
        delay_next     = delay_reg;
        period_next    = period_reg;
        found_next     = found_reg;
        fired_next     = fired_reg;
        pend_next      = pend_reg;
        due_next       = due_reg;
        best_next      = best_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        rsp_tag_next   = rsp_tag_reg;
        rsp_pend_next  = rsp_pend_reg;
        rsp_wait_next  = rsp_wait_reg;

        act_launch = '0;
        sum_launch = '0;
        sum_launch.best = ttt_pkg::TIME_MAX;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // last action result seen at the end of the row
        if (act_end.valid)
        begin
            found_next = act_end.found;
            fired_next = act_end.fired_tag;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    kind_next   = kind;
                    tag_next    = tag;
                    delay_next  = delay;
                    period_next = period;
                    if (kind == ttt_pkg::KIND_TICK)
                    begin
                        time_next = time_reg + ttt_pkg::ONE_TICK;
                    end
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                act_launch.valid = 1'b1;
                case (kind_reg)
                    ttt_pkg::KIND_START:  act_launch.op = ttt_pkg::OP_START;
                    ttt_pkg::KIND_CANCEL: act_launch.op = ttt_pkg::OP_CANCEL;
                    ttt_pkg::KIND_POLL:   act_launch.op = ttt_pkg::OP_SELECT;
                    default:              act_launch.op = ttt_pkg::OP_NOP;
                endcase
                state_next = (kind_reg == ttt_pkg::KIND_POLL) ? S_SELECT : S_SUMGO;
            end
            S_SELECT:
            begin
                if (act_end.valid)
                begin
                    act_launch.valid   = 1'b1;
                    act_launch.op      = ttt_pkg::OP_FIRE;
                    act_launch.best_ok = act_end.best_ok;
                    act_launch.best_dl = act_end.best_dl;
                    state_next         = S_SUMGO;
                end
            end
            S_SUMGO:
            begin
                sum_launch.valid = 1'b1;
                state_next       = S_WAIT;
            end
            S_WAIT:
            begin
                if (sum_end.valid)
                begin
                    pend_next  = sum_end.pending;
                    due_next   = sum_end.due;
                    best_next  = sum_end.best;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = done_status;
                    rsp_tag_next   = fired_reg;
                    rsp_pend_next  = pend_reg;
                    rsp_wait_next  = (pend_reg && !due_reg) ? best_reg : ttt_pkg::TIME_ZERO;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        tag_reg      <= tag_next;
        delay_reg    <= delay_next;
        period_reg   <= period_next;
        found_reg    <= found_next;
        fired_reg    <= fired_next;
        pend_reg     <= pend_next;
        due_reg      <= due_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        rsp_tag_reg  <= rsp_tag_next;
        rsp_pend_reg <= rsp_pend_next;
        rsp_wait_reg <= rsp_wait_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign fired_tag   = rsp_tag_reg;
    assign has_pending = rsp_pend_reg;
    assign wait_ticks  = rsp_wait_reg;

endmodule

`default_nettype wire

/* hw/rtl/tagged_timer_table_unit.sv */
// commands are taken one at a time: cmd_ready stays low from command transfer until
//   the response is registered; a poll sends a select wave and a fire wave where
//   start, cancel and tick send one action wave; every wave ripples through the row
//   of timer cells, one cell per cycle, and a held response stalls the next command
// reset: tick counter zero, every slot free and disarmed, no clearing pass
`default_nettype none

module tagged_timer_table_unit #(
    parameter int TIMER_SLOTS = ttt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire logic [ttt_pkg::KIND_W-1:0]      kind,
    input  wire logic [ttt_pkg::TAG_W-1:0]       tag,
    input  wire logic [ttt_pkg::DELAY_W-1:0]     delay,
    input  wire logic [ttt_pkg::PER_W-1:0]       period,
    // response channel
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic [ttt_pkg::STATUS_W-1:0]         status,
    output logic [ttt_pkg::TAG_W-1:0]            fired_tag,
    output logic                                 has_pending,
    output logic [ttt_pkg::TIME_W-1:0]           wait_ticks
);

    // the row: cell k reads link k and drives link k+1
    ttt_pkg::act_t   act_link [TIMER_SLOTS+1];
    ttt_pkg::sum_t   sum_link [TIMER_SLOTS+1];
    ttt_pkg::bcast_t bc;

    // sequencer
    //   start/cancel/tick: one action wave, then one summary wave launched the cycle after it
    //   poll: select wave finds the earliest due deadline, the fire wave then
    //   fires the lowest slot holding it, and the summary wave follows
    ttt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .kind        (kind),
        .tag         (tag),
        .delay       (delay),
        .period      (period),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .fired_tag   (fired_tag),
        .has_pending (has_pending),
        .wait_ticks  (wait_ticks),
        .bc          (bc),
        .act_launch  (act_link[0]),
        .sum_launch  (sum_link[0]),
        .act_end     (act_link[TIMER_SLOTS]),
        .sum_end     (sum_link[TIMER_SLOTS])
    );

    // timer cells; slots fill from cell 0 upward, so the free ones form a tail
    // and the first free cell a start wave meets is the append slot
    for (genvar k = 0; k < TIMER_SLOTS; k++)
    begin : g_cell
        ttt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .act_in  (act_link[k]),
            .sum_in  (sum_link[k]),
            .act_out (act_link[k+1]),
            .sum_out (sum_link[k+1])
        );
    end

endmodule

`default_nettype wire

/* hw/rtl/ttt_checker.sv */
`default_nettype none

module ttt_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            cmd_valid,
    input wire logic                            cmd_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [ttt_pkg::STATUS_W-1:0]    status,
    input wire logic [ttt_pkg::TAG_W-1:0]       fired_tag,
    input wire logic                            has_pending,
    input wire logic [ttt_pkg::TIME_W-1:0]      wait_ticks
);

    // one command in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while another is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)
                                        && $stable(fired_tag) && $stable(wait_ticks)))
        else $error("stalled response changed");

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (fired_tag != '0)) |-> (status == ttt_pkg::ST_OK))
        else $error("fired tag with a failing status");

    a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !has_pending) |-> (wait_ticks == '0))
        else $error("wait ticks with no timer armed");

    a_none_due: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ttt_pkg::ST_NONE_DUE)) |-> (fired_tag == '0))
        else $error("tag reported while nothing expired");

endmodule

bind tagged_timer_table_unit ttt_checker u_ttt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .fired_tag   (fired_tag),
    .has_pending (has_pending),
    .wait_ticks  (wait_ticks)
);

`default_nettype wire
